@@ design/bnc_pkg.sv @@
// Package for the bracket nesting checker: transaction types, opener codes and character codes.
`default_nettype none
package bnc_pkg;

  // Opener codes held on the bracket stack
  typedef enum logic [1:0] {
    CODE_ROUND  = 2'd0,
    CODE_SQUARE = 2'd1,
    CODE_CURLY  = 2'd2
  } bracket_code_t;

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // (
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // )
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // [
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ]
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // {
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // }

  localparam int unsigned DEPTH_W = 7;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic               final_res;
    logic [DEPTH_W-1:0] depth;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/bnc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bnc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/bracket_nesting_checker.sv @@
// Top level of the bracket nesting checker: stack control, verdict and result register.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   bnc_pkg::in_item_t  {ch, last}
//   out_     output     out_valid / out_ready bnc_pkg::out_item_t {ok, final_res, depth}
//
// One character per cycle while the output is not stalled, one result per character; the result
// appears in the output register in the cycle after the character is taken.
// The top of the stack sits in a register; the RAM read port keeps the entry
// beneath the top prefetched, so a pop does not wait on the RAM read.
// in_ready stays high while the output register is empty or being drained.
// Synchronous active-low reset clears level, counters, error flag and out_valid;
// the RAM needs no clearing pass since only entries written by pushes are read.
`default_nettype none
module bracket_nesting_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bnc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bnc_pkg::out_item_t      out_data
);

  import bnc_pkg::*;

  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // Architectural state
  logic [LW-1:0]  level_r, level_nxt;
  logic [LW-1:0]  round_r, round_nxt;
  logic [LW-1:0]  square_r, square_nxt;
  logic           err_r, err_nxt;
  bracket_code_t  top_r, top_nxt;
  logic           out_valid_r;
  out_item_t      out_data_r, out_data_nxt;

  // Character decode
  logic          is_open, is_close;
  bracket_code_t code;

  // Handled values, before the end-of-expression clear
  logic [LW-1:0] h_level, h_round, h_square;
  logic          h_err;
  bracket_code_t h_top;

  logic          accept;
  logic          full, push_ok, do_push;
  logic [1:0]    under_code;
  logic [LW-1:0] raddr_full;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign full     = (level_r == LW'(STACK_DEPTH));

  always_comb begin
    is_open  = 1'b0;
    is_close = 1'b0;
    code     = CODE_ROUND;
    unique case (in_data.ch)
      CH_OPEN_ROUND:   begin is_open  = 1'b1; code = CODE_ROUND;  end
      CH_OPEN_SQUARE:  begin is_open  = 1'b1; code = CODE_SQUARE; end
      CH_OPEN_CURLY:   begin is_open  = 1'b1; code = CODE_CURLY;  end
      CH_CLOSE_ROUND:  begin is_close = 1'b1; code = CODE_ROUND;  end
      CH_CLOSE_SQUARE: begin is_close = 1'b1; code = CODE_SQUARE; end
      CH_CLOSE_CURLY:  begin is_close = 1'b1; code = CODE_CURLY;  end
      default:         begin end
    endcase
  end

  assign push_ok = is_open && !full;
  assign do_push = accept && !err_r && push_ok;

  // Handle one character; once an error is flagged, hold everything
  always_comb begin
    h_level  = level_r;
    h_round  = round_r;
    h_square = square_r;
    h_err    = err_r;
    h_top    = top_r;
    if (!err_r) begin
      if (is_open) begin
        if (full) begin
          h_err = 1'b1;
        end else begin
          h_level = level_r + LW'(1);
          h_top   = code;
          if (code == CODE_ROUND)  h_round  = round_r + LW'(1);
          if (code == CODE_SQUARE) h_square = square_r + LW'(1);
        end
        // hierarchy rules look at counts from before this push
        if (code == CODE_SQUARE && round_r != '0) h_err = 1'b1;
        if (code == CODE_CURLY && square_r != '0) h_err = 1'b1;
      end else if (is_close) begin
        if (level_r == '0) begin
          h_err = 1'b1;
        end else begin
          h_level = level_r - LW'(1);
          h_top   = bracket_code_t'(under_code);
          if (top_r == CODE_ROUND && round_r != '0)   h_round  = round_r - LW'(1);
          if (top_r == CODE_SQUARE && square_r != '0) h_square = square_r - LW'(1);
          if (top_r != code) h_err = 1'b1;
        end
      end
    end
  end

  // Advance state on a taken transaction; clear after the last character
  always_comb begin
    level_nxt  = level_r;
    round_nxt  = round_r;
    square_nxt = square_r;
    err_nxt    = err_r;
    top_nxt    = top_r;
    if (accept) begin
      if (in_data.last) begin
        level_nxt  = '0;
        round_nxt  = '0;
        square_nxt = '0;
        err_nxt    = 1'b0;
      end else begin
        level_nxt  = h_level;
        round_nxt  = h_round;
        square_nxt = h_square;
        err_nxt    = h_err;
      end
      top_nxt = h_top;
    end
  end

  // Verdict: on the last character an open bracket left over also fails
  always_comb begin
    out_data_nxt.ok        = !h_err && !(in_data.last && h_level != '0);
    out_data_nxt.final_res = in_data.last;
    out_data_nxt.depth     = DEPTH_W'(h_level);
  end

  // Prefetch the entry beneath the next top of stack
  assign raddr_full = level_nxt - LW'(2);

  bnc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_push),
    .waddr (level_r[AW-1:0]),
    .wdata (code),
    .raddr (raddr_full[AW-1:0]),
    .rdata (under_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      round_r     <= '0;
      square_r    <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      level_r  <= level_nxt;
      round_r  <= round_nxt;
      square_r <= square_nxt;
      err_r    <= err_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ design/bnc_checker.sv @@
// Port-level assertions for the bracket nesting checker, bound to the top level.
`default_nettype none
module bnc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire bnc_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire bnc_pkg::out_item_t out_data
);

  import bnc_pkg::*;

  // Every taken character yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after a taken transaction");

  // The final flag tracks the last flag of the character it belongs to
  a_final_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_data.final_res == $past(in_data.last))
    else $error("final_res does not match last");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind bracket_nesting_checker bnc_checker u_bnc_checker (.*);
`default_nettype wire
